/* rtl/efst_pkg.sv */
// shared types and constants for the eigen frame similarity transform core
// no dependencies; imported by every module of the block
package efst_pkg;

    // input word: two eigen descriptors and the scale, Q16.16; eigenvalues are unsigned Q15.16
    typedef struct packed {
        logic signed [31:0] scale_d;
        logic signed [31:0] src_axis_x;
        logic signed [31:0] src_axis_y;
        logic        [30:0] src_eigen;
        logic signed [31:0] src_pos_x;
        logic signed [31:0] src_pos_y;
        logic signed [31:0] dst_axis_x;
        logic signed [31:0] dst_axis_y;
        logic        [30:0] dst_eigen;
        logic signed [31:0] dst_pos_x;
        logic signed [31:0] dst_pos_y;
    } t_in_word;

    // output word: similarity coefficients, translation and fault flag
    typedef struct packed {
        logic signed [31:0] lin_a;
        logic signed [31:0] lin_b;
        logic signed [31:0] lin_c;
        logic signed [31:0] lin_e;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic               fault;
    } t_out_word;

    // saturation limits
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // solve divider: one prep stage, one stage per quotient bit, one output stage
    localparam int QDIV_STEPS = 31;
    localparam int QDIV_LAT   = QDIV_STEPS + 2;

    // eigen ratio: long division of the 63 bit ratio, then a digit root
    localparam int RDIV_STEPS = 63;
    localparam int SQRT_STEPS = 32;
    localparam int RATIO_LAT  = RDIV_STEPS + SQRT_STEPS;

    // stages ahead of the solve divider, alignment and finishing stages
    localparam int MAIN_PRE   = 4;
    localparam int ALIGN_LAT  = RATIO_LAT - MAIN_PRE - QDIV_LAT;
    localparam int OUT_LAT    = 5;
    localparam int PIPE_LAT   = RATIO_LAT + OUT_LAT;

endpackage

/* rtl/efst_qdiv.sv */
// pipelined signed Q16.16 divider against a negative definite determinant
// depends on efst_pkg; one quotient bit per stage
module efst_qdiv (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_num,
    input  logic        [62:0] i_den,
    output logic signed [31:0] o_quo,
    output logic               o_dz
);
    import efst_pkg::*;

    logic [62:0]         r_rem [0:QDIV_STEPS];
    logic [30:0]         r_sh  [0:QDIV_STEPS];
    logic [62:0]         r_den [0:QDIV_STEPS];
    logic [QDIV_STEPS:0] r_neg;
    logic [QDIV_STEPS:0] r_sat;
    logic [62:0]         w_mag;
    logic                n_sat;
    logic signed [31:0]  w_pos;
    logic signed [31:0]  n_quo;
    logic signed [31:0]  r_quo;
    logic                r_dz;

    // prep: magnitude, sign and overflow check (integer part of 2^15 or more)
    always_comb begin
        w_mag = i_num[63] ? 63'(-i_num) : i_num[62:0];
        n_sat = {15'd0, w_mag[62:15]} >= i_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {15'd0, w_mag[62:15]};
            r_sh[0]  <= {w_mag[14:0], 16'd0};
            r_den[0] <= i_den;
            r_neg[0] <= ~i_num[63];
            r_sat[0] <= n_sat;
        end
    end

    // restoring steps: dividend bits shift out the top, quotient bits in the bottom
    genvar k;
    for (k = 1; k <= QDIV_STEPS; k++) begin : g_step
        logic [63:0] w_trial;
        logic [63:0] w_diff;
        logic        w_ge;

        always_comb begin
            w_trial = {r_rem[k-1], r_sh[k-1][30]};
            w_diff  = w_trial - {1'b0, r_den[k-1]};
            w_ge    = w_trial >= {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[62:0] : w_trial[62:0];
                r_sh[k]  <= {r_sh[k-1][29:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    // output: apply sign or saturate
    always_comb begin
        w_pos = {1'b0, r_sh[QDIV_STEPS]};
        if (r_sat[QDIV_STEPS]) begin
            n_quo = r_neg[QDIV_STEPS] ? Q_MIN : Q_MAX;
        end else begin
            n_quo = r_neg[QDIV_STEPS] ? -w_pos : w_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
            r_dz  <= (r_den[QDIV_STEPS] == 63'd0);
        end
    end

    assign o_quo = r_quo;
    assign o_dz  = r_dz;

endmodule

/* rtl/efst_ratio.sv */
// eigenvalue ratio root: floor(sqrt(floor(dst * 2^32 / src)))
// depends on efst_pkg; bit serial division then digit root
module efst_ratio (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_et,
    input  logic [30:0] i_es,
    output logic [31:0] o_root
);
    import efst_pkg::*;

    logic [30:0] r_rem [0:RDIV_STEPS-1];
    logic [62:0] r_w   [0:RDIV_STEPS-1];
    logic [30:0] r_es  [0:RDIV_STEPS-1];
    logic [33:0] r_srem [0:SQRT_STEPS-1];
    logic [31:0] r_root [0:SQRT_STEPS-1];
    logic [63:0] r_rad  [0:SQRT_STEPS-1];

    // division: shared register holds remaining dividend bits and the quotient
    genvar k;
    for (k = 0; k < RDIV_STEPS; k++) begin : g_div
        logic [30:0] w_rem;
        logic [62:0] w_w;
        logic [30:0] w_es;
        logic [31:0] w_trial;
        logic [31:0] w_diff;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem = '0;
            assign w_w   = {i_et, 32'd0};
            assign w_es  = i_es;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_w   = r_w[k-1];
            assign w_es  = r_es[k-1];
        end

        always_comb begin
            w_trial = {w_rem, w_w[62]};
            w_diff  = w_trial - {1'b0, w_es};
            w_ge    = w_trial >= {1'b0, w_es};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[30:0] : w_trial[30:0];
                r_w[k]   <= {w_w[61:0], w_ge};
                r_es[k]  <= w_es;
            end
        end
    end

    // digit root: two radicand bits per stage
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [63:0] w_rad;
        logic [35:0] w_t;
        logic [35:0] w_trial;
        logic [35:0] w_diff;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = {1'b0, r_w[RDIV_STEPS-1]};
        end else begin : g_next
            assign w_rem  = r_srem[k-1];
            assign w_root = r_root[k-1];
            assign w_rad  = r_rad[k-1];
        end

        always_comb begin
            w_t     = {w_rem, w_rad[63:62]};
            w_trial = {2'b00, w_root, 2'b01};
            w_diff  = w_t - w_trial;
            w_ge    = w_t >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[k] <= w_ge ? w_diff[33:0] : w_t[33:0];
                r_root[k] <= {w_root[30:0], w_ge};
                r_rad[k]  <= {w_rad[61:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule

/* rtl/eigen_frame_similarity_transform_core.sv */
// top level of the eigen frame similarity transform core
// depends on efst_pkg, efst_qdiv and efst_ratio
//
// Fully pipelined: one word is taken every clock cycle unless the output stalls.
// The pipeline depth is set by the eigen ratio path, a 63 stage bit-serial
// divider followed by a 32 stage root extractor; the axis solve (two 33 stage
// dividers) is delay-matched to it, and five finishing stages scale the pair
// and form the translations. When the output word is not taken the whole
// pipeline holds, so in_ready follows out_ready whenever the output register
// is full. A singular axis system or a zero eigenvalue gives fault set and all
// six coefficients zero.
module eigen_frame_similarity_transform_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  efst_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output efst_pkg::t_out_word o_out_word
);
    import efst_pkg::*;

    // side data carried alongside the ratio path
    typedef struct packed {
        logic signed [31:0] spx;
        logic signed [31:0] spy;
        logic signed [31:0] tpx;
        logic signed [31:0] tpy;
        logic               bad;
    } t_side;

    // solved pair waiting for the ratio root
    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] xy;
        logic               sing;
    } t_sol;

    // trunc(p / 2^16) toward zero
    function automatic logic signed [47:0] f_trunc16(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p[63] ? (p + 64'sd65535) : p;
        return adj[63:16];
    endfunction

    // symmetric saturation for the matrix entries
    function automatic logic signed [31:0] f_symsat(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > 48'sd2147483647) begin
            res = Q_MAX;
        end else if (v < -48'sd2147483647) begin
            res = -Q_MAX;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // two's complement saturation to 32 bits
    function automatic logic signed [31:0] f_sat32(input logic signed [49:0] v);
        logic signed [31:0] res;
        if (v > 50'sd2147483647) begin
            res = Q_MAX;
        end else if (v < -50'sd2147483648) begin
            res = Q_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic                w_en;
    logic [PIPE_LAT:1]   r_vld;

    logic signed [63:0]  r_s1_pdx, r_s1_pdy;
    logic signed [31:0]  r_s1_tx, r_s1_ty;
    logic signed [31:0]  r_s2_a00, r_s2_a01, r_s2_tx, r_s2_ty;
    logic signed [63:0]  r_s3_a00tx, r_s3_a01ty, r_s3_a00ty, r_s3_a01tx;
    logic signed [63:0]  r_s3_sq0, r_s3_sq1;
    logic signed [63:0]  r_s4_nx, r_s4_ny;
    logic        [62:0]  r_s4_ud;

    logic signed [31:0]  w_xx, w_xy;
    logic                w_dzx, w_dzy;
    logic        [31:0]  w_root;

    t_side               r_side [1:RATIO_LAT];
    t_side               n_side;
    t_sol                r_aln  [1:ALIGN_LAT];

    logic signed [63:0]  r_f1_pa, r_f1_pb;
    t_side               r_f1_side;
    logic                r_f1_flt;
    logic signed [31:0]  r_f2_la, r_f2_lb, r_f2_lc;
    t_side               r_f2_side;
    logic                r_f2_flt;
    logic signed [63:0]  r_f3_m0, r_f3_m1, r_f3_m2, r_f3_m3;
    logic signed [31:0]  r_f3_la, r_f3_lb, r_f3_lc;
    logic signed [31:0]  r_f3_tpx, r_f3_tpy;
    logic                r_f3_flt;
    logic signed [47:0]  r_f4_t0, r_f4_t1, r_f4_t2, r_f4_t3;
    logic signed [31:0]  r_f4_la, r_f4_lb, r_f4_lc;
    logic signed [31:0]  r_f4_tpx, r_f4_tpy;
    logic                r_f4_flt;
    logic signed [47:0]  w_pb_tr;
    logic signed [49:0]  w_sx, w_sy;
    t_out_word           n_out;
    t_out_word           r_out;

    // whole pipeline advances unless a finished word is held at the output
    assign w_en        = ~r_vld[PIPE_LAT] | i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[PIPE_LAT];
    assign o_out_word  = r_out;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-1:1], i_in_valid};
        end
    end

    // matrix entries (d times source axis), their products with the target axis and squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pdx <= i_in_word.scale_d * i_in_word.src_axis_x;
            r_s1_pdy <= i_in_word.scale_d * i_in_word.src_axis_y;
            r_s1_tx  <= i_in_word.dst_axis_x;
            r_s1_ty  <= i_in_word.dst_axis_y;

            r_s2_a00 <= f_symsat(f_trunc16(r_s1_pdx));
            r_s2_a01 <= f_symsat(f_trunc16(r_s1_pdy));
            r_s2_tx  <= r_s1_tx;
            r_s2_ty  <= r_s1_ty;

            r_s3_a00tx <= r_s2_a00 * r_s2_tx;
            r_s3_a01ty <= r_s2_a01 * r_s2_ty;
            r_s3_a00ty <= r_s2_a00 * r_s2_ty;
            r_s3_a01tx <= r_s2_a01 * r_s2_tx;
            r_s3_sq0   <= r_s2_a00 * r_s2_a00;
            r_s3_sq1   <= r_s2_a01 * r_s2_a01;

            // numerators and minus the determinant
            r_s4_nx <= -r_s3_a00tx - r_s3_a01ty;
            r_s4_ny <= r_s3_a00ty - r_s3_a01tx;
            r_s4_ud <= r_s3_sq0[62:0] + r_s3_sq1[62:0];
        end
    end

    efst_qdiv u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s4_nx),
        .i_den (r_s4_ud),
        .o_quo (w_xx),
        .o_dz  (w_dzx)
    );

    efst_qdiv u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s4_ny),
        .i_den (r_s4_ud),
        .o_quo (w_xy),
        .o_dz  (w_dzy)
    );

    efst_ratio u_ratio (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_et   (i_in_word.dst_eigen),
        .i_es   (i_in_word.src_eigen),
        .o_root (w_root)
    );

    // centres and ratio fault ride along the ratio path
    always_comb begin
        n_side.spx = i_in_word.src_pos_x;
        n_side.spy = i_in_word.src_pos_y;
        n_side.tpx = i_in_word.dst_pos_x;
        n_side.tpy = i_in_word.dst_pos_y;
        n_side.bad = (i_in_word.src_eigen == 31'd0) | (i_in_word.dst_eigen == 31'd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[1] <= n_side;
            for (int i = 2; i <= RATIO_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_aln[1] <= '{xx: w_xx, xy: w_xy, sing: w_dzx | w_dzy};
            for (int i = 2; i <= ALIGN_LAT; i++) begin
                r_aln[i] <= r_aln[i-1];
            end
        end
    end

    // finishing stages: scale by the root, then translations
    assign w_pb_tr = f_trunc16(r_f1_pb);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_pa   <= r_aln[ALIGN_LAT].xx * $signed({1'b0, w_root});
            r_f1_pb   <= r_aln[ALIGN_LAT].xy * $signed({1'b0, w_root});
            r_f1_side <= r_side[RATIO_LAT];
            r_f1_flt  <= r_aln[ALIGN_LAT].sing | r_side[RATIO_LAT].bad;

            r_f2_la   <= f_sat32(50'(f_trunc16(r_f1_pa)));
            r_f2_lb   <= f_sat32(50'(w_pb_tr));
            r_f2_lc   <= f_sat32(-50'(w_pb_tr));
            r_f2_side <= r_f1_side;
            r_f2_flt  <= r_f1_flt;

            r_f3_m0  <= r_f2_la * r_f2_side.spx;
            r_f3_m1  <= r_f2_lb * r_f2_side.spy;
            r_f3_m2  <= r_f2_lc * r_f2_side.spx;
            r_f3_m3  <= r_f2_la * r_f2_side.spy;
            r_f3_la  <= r_f2_la;
            r_f3_lb  <= r_f2_lb;
            r_f3_lc  <= r_f2_lc;
            r_f3_tpx <= r_f2_side.tpx;
            r_f3_tpy <= r_f2_side.tpy;
            r_f3_flt <= r_f2_flt;

            r_f4_t0  <= f_trunc16(r_f3_m0);
            r_f4_t1  <= f_trunc16(r_f3_m1);
            r_f4_t2  <= f_trunc16(r_f3_m2);
            r_f4_t3  <= f_trunc16(r_f3_m3);
            r_f4_la  <= r_f3_la;
            r_f4_lb  <= r_f3_lb;
            r_f4_lc  <= r_f3_lc;
            r_f4_tpx <= r_f3_tpx;
            r_f4_tpy <= r_f3_tpy;
            r_f4_flt <= r_f3_flt;

            r_out <= n_out;
        end
    end

    // output word, zeroed on fault
    always_comb begin
        w_sx = 50'(r_f4_tpx) - (50'(r_f4_t0) + 50'(r_f4_t1));
        w_sy = 50'(r_f4_tpy) - (50'(r_f4_t2) + 50'(r_f4_t3));
        if (r_f4_flt) begin
            n_out       = '0;
            n_out.fault = 1'b1;
        end else begin
            n_out.lin_a   = r_f4_la;
            n_out.lin_b   = r_f4_lb;
            n_out.lin_c   = r_f4_lc;
            n_out.lin_e   = r_f4_la;
            n_out.shift_x = f_sat32(w_sx);
            n_out.shift_y = f_sat32(w_sy);
            n_out.fault   = 1'b0;
        end
    end

endmodule

/* verif/tb.sv */
// self-checking bench for eigen_frame_similarity_transform_core
// depends on efst_pkg and the core; predicts each result word in fixed point
`timescale 1ns / 100ps

module tb;
    import efst_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam int N_RANDOM = 930;
    localparam int MAX_WAIT = 18;
    localparam int HOLD_AT  = 150;
    localparam int HOLD_LEN = 400;
    localparam int DRAIN    = 200;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    t_in_word  pend_q[$];
    t_out_word xform_q[$];

    int  n_sent = 0;
    int  n_recv = 0;
    int  n_fault = 0;
    int  n_err = 0;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    bit  hold_done;
    bit  burst = 1'b0;
    logic sink_rdy = 1'b1;

    eigen_frame_similarity_transform_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    assign i_out_ready = sink_rdy && (hold_left == 0);

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // fixed point helpers
    function automatic wide_t qmul(wide_t a, wide_t b);
        wide_t p;
        p = a * b;
        if (p < 0) return -((-p) >> 16);
        return p >> 16;
    endfunction

    function automatic wide_t sat32(wide_t v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic wide_t symsat(wide_t v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483647) return -64'sd2147483647;
        return v;
    endfunction

    // trunc(n * 2^16 / d), saturated when the integer part is too big
    function automatic wide_t qdiv(wide_t n, wide_t d);
        bit    neg;
        wide_t un;
        wide_t ud;
        wide_t m;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? -n : n;
        ud  = (d < 0) ? -d : d;
        if (un / ud >= 32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
        m = (un << 16) / ud;
        return neg ? -m : m;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // expected result word for one descriptor pair
    function automatic t_out_word similarity_of(t_in_word w);
        t_out_word   o;
        wide_t       d, vx, vy, tx, ty, spx, spy, tpx, tpy;
        wide_t       a00, a01, a11, det, xx, xy, la, lb, lc, pb, rr, sx, sy;
        logic [63:0] q;
        d   = $signed(w.scale_d);
        vx  = $signed(w.src_axis_x);
        vy  = $signed(w.src_axis_y);
        spx = $signed(w.src_pos_x);
        spy = $signed(w.src_pos_y);
        tx  = $signed(w.dst_axis_x);
        ty  = $signed(w.dst_axis_y);
        tpx = $signed(w.dst_pos_x);
        tpy = $signed(w.dst_pos_y);
        o   = '0;
        a00 = symsat(qmul(d, vx));
        a01 = symsat(qmul(d, vy));
        a11 = -a00;
        det = a00 * a11 - a01 * a01;
        q   = '0;
        if (w.src_eigen != 0) q = {1'b0, w.dst_eigen, 32'b0} / {33'b0, w.src_eigen};
        if (det == 0 || q == 0) begin
            o.fault = 1'b1;
            return o;
        end
        xx = qdiv(a11 * tx - a01 * ty, det);
        xy = qdiv(a00 * ty - a01 * tx, det);
        rr = {64'b0, root64(q)};
        la = sat32(qmul(xx, rr));
        pb = qmul(xy, rr);
        lb = sat32(pb);
        lc = sat32(-pb);
        sx = sat32(tpx - (qmul(la, spx) + qmul(lb, spy)));
        sy = sat32(tpy - (qmul(lc, spx) + qmul(la, spy)));
        o.lin_a   = la[31:0];
        o.lin_b   = lb[31:0];
        o.lin_c   = lc[31:0];
        o.lin_e   = la[31:0];
        o.shift_x = sx[31:0];
        o.shift_y = sy[31:0];
        return o;
    endfunction

    function automatic t_in_word wild_word();
        t_in_word     w;
        logic [351:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[349:0];
        return w;
    endfunction

    // plausible descriptors: moderate axes and eigenvalues, small offsets
    function automatic t_in_word tame_word();
        t_in_word w;
        w.scale_d    = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        w.src_axis_x = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        w.src_axis_y = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        w.dst_axis_x = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        w.dst_axis_y = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        w.src_eigen  = 31'($urandom_range(0, 32'h0100_0000));
        w.dst_eigen  = 31'($urandom_range(0, 32'h0100_0000));
        w.src_pos_x  = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        w.src_pos_y  = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        w.dst_pos_x  = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        w.dst_pos_y  = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        return w;
    endfunction

    // driver: one word offered at a time, random gap drawn per word outside bursts
    always @(posedge i_clk) begin
        bit took;
        took = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                took = 1'b1;
                xform_q.push_back(similarity_of(i_in_word));
                n_sent <= n_sent + 1;
                if (n_sent % 120 == 0) burst <= ~burst;
            end
            if (!i_in_valid || took) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pend_q.pop_front();
                    send_gap   <= burst ? 0 : $urandom_range(0, MAX_WAIT);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the pipeline fills and stalls the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: compare each taken result word with the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        int        gap;
        if (!i_rst_n) begin
            sink_rdy <= 1'b1;
            recv_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_recv <= n_recv + 1;
                if (xform_q.size() == 0) begin
                    n_err <= n_err + 1;
                    if (n_err < 10) $display("unexpected result word %h", o_out_word);
                end else begin
                    want = xform_q.pop_front();
                    if (want.fault) n_fault <= n_fault + 1;
                    if (want.lin_a !== o_out_word.lin_a || want.lin_b !== o_out_word.lin_b ||
                        want.lin_c !== o_out_word.lin_c || want.lin_e !== o_out_word.lin_e ||
                        want.shift_x !== o_out_word.shift_x ||
                        want.shift_y !== o_out_word.shift_y ||
                        want.fault !== o_out_word.fault) begin
                        n_err <= n_err + 1;
                        if (n_err < 10)
                            $display("mismatch at result %0d: expected %h actual %h",
                                     n_recv, want, o_out_word);
                    end
                end
                gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
                if (gap == 0) begin
                    sink_rdy <= 1'b1;
                    recv_gap <= 0;
                end else begin
                    recv_gap <= gap - 1;
                    sink_rdy <= 1'b0;
                end
            end else if (!sink_rdy) begin
                if (recv_gap > 0) recv_gap <= recv_gap - 1;
                else sink_rdy <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        t_in_word w;

        // all zero: singular and zero eigenvalues
        pend_q.push_back('0);
        // unit case, identity-like
        w = '0;
        w.scale_d = 32'sh0001_0000; w.src_axis_x = 32'sh0001_0000;
        w.dst_axis_x = 32'sh0001_0000; w.src_eigen = 31'h0001_0000;
        w.dst_eigen = 31'h0004_0000; w.dst_pos_x = 32'sh0003_0000;
        w.src_pos_y = 32'sh0002_0000;
        pend_q.push_back(w);
        // zero scale makes the system singular
        w.scale_d = '0; pend_q.push_back(w);
        // zero source axis
        w.scale_d = 32'sh0001_0000; w.src_axis_x = '0; pend_q.push_back(w);
        // zero source eigenvalue
        w.src_axis_x = 32'sh0001_0000; w.src_eigen = '0; pend_q.push_back(w);
        // zero target eigenvalue gives a zero ratio
        w.src_eigen = 31'h0001_0000; w.dst_eigen = '0; pend_q.push_back(w);
        // largest ratio: tiny source, huge target eigenvalue
        w.src_eigen = 31'h1; w.dst_eigen = 31'h7FFF_FFFF; pend_q.push_back(w);
        // smallest nonzero ratio
        w.src_eigen = 31'h7FFF_FFFF; w.dst_eigen = 31'h1; pend_q.push_back(w);
        // field extremes: all ones, all minimum, then mixed maximum and minimum
        pend_q.push_back('1);
        w = '0;
        w.scale_d = Q_MIN; w.src_axis_x = Q_MIN; w.src_axis_y = Q_MIN;
        w.dst_axis_x = Q_MIN; w.dst_axis_y = Q_MIN; w.src_pos_x = Q_MIN;
        w.src_pos_y = Q_MIN; w.dst_pos_x = Q_MIN; w.dst_pos_y = Q_MIN;
        w.src_eigen = 31'h7FFF_FFFF; w.dst_eigen = 31'h7FFF_FFFF;
        pend_q.push_back(w);
        w.scale_d = Q_MAX; w.src_axis_x = Q_MAX; w.src_axis_y = Q_MIN;
        w.dst_axis_x = Q_MAX; w.dst_axis_y = Q_MAX; w.src_pos_x = Q_MAX;
        w.src_pos_y = Q_MAX; w.dst_pos_x = Q_MAX; w.dst_pos_y = Q_MIN;
        pend_q.push_back(w);
        // tiny source axis, large target: solve saturates
        w = '0;
        w.scale_d = 32'sh0000_0100; w.src_axis_x = 32'sh0000_0100;
        w.dst_axis_x = Q_MAX; w.dst_axis_y = Q_MIN;
        w.src_eigen = 31'h0000_0001; w.dst_eigen = 31'h7FFF_0000;
        w.src_pos_x = Q_MAX; w.src_pos_y = Q_MIN;
        pend_q.push_back(w);
        // small product truncates to a zero matrix
        w.scale_d = 32'sh0000_0001; w.src_axis_x = 32'sh0000_0001;
        pend_q.push_back(w);
        // negative scale and axis y only
        w = '0;
        w.scale_d = -32'sh0001_0000; w.src_axis_y = 32'sh0000_8000;
        w.dst_axis_y = -32'sh0000_4000; w.src_eigen = 31'h0002_0000;
        w.dst_eigen = 31'h0000_8000; w.src_pos_x = -32'sh0010_0000;
        w.dst_pos_y = 32'sh0001_8000;
        pend_q.push_back(w);
        for (int i = 0; i < 6; i++) pend_q.push_back(wild_word());

        // random part: mostly plausible descriptors, some raw noise
        for (int i = 0; i < N_RANDOM; i++)
            pend_q.push_back(($urandom_range(0, 3) == 0) ? wild_word() : tame_word());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (xform_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("sent %0d words, checked %0d results (%0d faults), one long output stall",
                 n_sent, n_recv, n_fault);
        $display("mismatches: %0d", n_err);
        if (n_err == 0 && xform_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/efst_pkg.sv
rtl/efst_qdiv.sv
rtl/efst_ratio.sv
rtl/eigen_frame_similarity_transform_core.sv
verif/tb.sv
